// ----- rtl/core/sse_data_line_extractor_macros.svh -----
// Assertion macros shared by the data line extractor RTL.
// Depends on nothing; files that assert include it by its bare name.
`ifndef SSE_DATA_LINE_EXTRACTOR_MACROS_SVH
`define SSE_DATA_LINE_EXTRACTOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SSE_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sse data line extractor: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define SSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sse data line extractor: next-cycle check failed");

`endif

// ----- rtl/core/sse_dlx_pkg.sv -----
// Package for the data line extractor: word types, queue command type and constants.
// Depends on nothing; used by every module of the block.
package sse_dlx_pkg;

  localparam int LINE_CAP = 4096;
  localparam int LINE_W   = $clog2(LINE_CAP);
  localparam int TAG_LEN  = 6;
  localparam int QDEPTH   = 4;
  localparam int QPTR_W   = $clog2(QDEPTH);

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  // "data: "
  localparam logic [7:0] DATA_TAG [0:5] = '{8'h64, 8'h61, 8'h74, 8'h61, 8'h3A, 8'h20};
  // "[DONE]"
  localparam logic [7:0] DONE_TAG [0:5] = '{8'h5B, 8'h44, 8'h4F, 8'h4E, 8'h45, 8'h5D};

  typedef enum logic {
    KIND_BYTE  = 1'b0,
    KIND_ABORT = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] byte_value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       message_end;
    logic       run_last;
  } out_word_t;

  // One queued command: some held bytes, an optional tail byte, an optional end marker.
  typedef struct packed {
    logic [5:0][7:0] held;
    logic [2:0]      held_cnt;
    logic            has_tail;
    logic [7:0]      tail;
    logic            has_end;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/core/sse_data_line_extractor.sv -----
// Server-sent-events data line extractor, top level.
// An input word's output passes the queue entry, the command and the output register.
// Throughput: one input word per cycle while the queue has room; the back end sends
// one output word per cycle unless stalled; seven words from a line start keep it busy.
// Reset: rst is synchronous and active high; it clears line state, abort and the queue.
`include "sse_data_line_extractor_macros.svh"

module sse_data_line_extractor
  import sse_dlx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      rx_valid,
  output logic      rx_stall,
  input  in_word_t  rx_word,
  output logic      msg_valid,
  input  logic      msg_stall,
  output out_word_t msg_word
);

  // The front end takes a word whenever the command queue has room. Words that
  // produce no output (prefix bytes, held payload bytes, empty lines, anything
  // after an abort) never touch the queue, so the input rarely stalls.
  logic    accept;
  logic    push;
  cmd_t    push_cmd;
  logic    pop;
  cmd_t    pop_cmd;
  q_stat_t q_stat;
  logic    end_word;

  assign rx_stall = q_stat.full;
  assign accept   = rx_valid && !rx_stall;

  // Line parsing: prefix match, held payload bytes and the [DONE] check.
  sse_dlx_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .rx_word  (rx_word),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Each queue entry carries a snapshot of the held bytes, so the front end can
  // start filling them for the next line while the back end still drains.
  sse_dlx_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .stat     (q_stat)
  );

  // The back end turns one command into held bytes, tail byte and end marker,
  // with its own output register against the downstream stall.
  sse_dlx_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_cmd   (pop_cmd),
    .q_stat    (q_stat),
    .pop       (pop),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg_word  (msg_word)
  );

  // An output word on offer that closes a message.
  assign end_word = msg_valid && msg_word.message_end;

  // An end marker carries no byte and always closes the run of its input word.
  `SSE_ASSERT_IMPL(a_end_marker_form, clk, rst, end_word, msg_word.run_last && !msg_word.byte_valid)
  // The front end never writes into a full queue.
  `SSE_ASSERT_IMPL(a_no_overflow, clk, rst, q_stat.full, !push)
  // Nothing is pushed in the cycle after an abort word is taken.
  `SSE_ASSERT_NEXT(a_abort_quiet, clk, rst, accept && rx_word.kind == KIND_ABORT, !push)

endmodule

// ----- rtl/core/sse_dlx_front.sv -----
// Front end of the data line extractor: takes words, tracks line state, issues commands.
// Depends on sse_dlx_pkg.
module sse_dlx_front
  import sse_dlx_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_word_t rx_word,
  output logic     push,
  output cmd_t     push_cmd
);

  logic [LINE_W-1:0] line_count;
  logic              prefix_ok;
  logic              done_match;
  logic              streaming;
  logic              aborted;
  logic [5:0][7:0]   held;

  logic [LINE_W-1:0] line_count_next;
  logic              prefix_ok_next;
  logic              done_match_next;
  logic              streaming_next;
  logic              aborted_next;
  logic              held_we;

  logic [7:0]        c;
  logic [LINE_W-1:0] dlen;
  logic [LINE_W-1:0] q;

  assign c    = rx_word.byte_value;
  assign dlen = line_count - LINE_W'(TAG_LEN);
  assign q    = line_count - LINE_W'(TAG_LEN);

  always_comb begin
    line_count_next = line_count;
    prefix_ok_next  = prefix_ok;
    done_match_next = done_match;
    streaming_next  = streaming;
    aborted_next    = aborted;
    held_we         = 1'b0;
    push            = 1'b0;
    push_cmd        = '0;
    push_cmd.held   = held;
    if (accept && !aborted) begin
      if (rx_word.kind == KIND_ABORT) begin
        aborted_next = 1'b1;
      end else if (c == CHAR_LF || c == CHAR_CR) begin
        if (line_count != '0) begin
          if (prefix_ok && line_count > LINE_W'(TAG_LEN)) begin
            if (streaming) begin
              push             = 1'b1;
              push_cmd.has_end = 1'b1;
            end else if (!(dlen == LINE_W'(TAG_LEN) && done_match)) begin
              push             = 1'b1;
              push_cmd.has_end = 1'b1;
              push_cmd.held_cnt = (dlen >= LINE_W'(TAG_LEN)) ? 3'd6 : dlen[2:0];
            end
          end
          line_count_next = '0;
          prefix_ok_next  = 1'b1;
          done_match_next = 1'b1;
          streaming_next  = 1'b0;
        end
      end else if (line_count < LINE_W'(LINE_CAP - 1)) begin
        line_count_next = line_count + LINE_W'(1);
        if (line_count < LINE_W'(TAG_LEN)) begin
          if (c != DATA_TAG[line_count[2:0]]) begin
            prefix_ok_next = 1'b0;
          end
        end else if (prefix_ok) begin
          if (q < LINE_W'(TAG_LEN)) begin
            held_we = 1'b1;
            if (c != DONE_TAG[q[2:0]]) begin
              done_match_next = 1'b0;
            end
          end else if (q == LINE_W'(TAG_LEN)) begin
            push              = 1'b1;
            push_cmd.held_cnt = 3'd6;
            push_cmd.has_tail = 1'b1;
            push_cmd.tail     = c;
            streaming_next    = 1'b1;
          end else begin
            push              = 1'b1;
            push_cmd.has_tail = 1'b1;
            push_cmd.tail     = c;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      prefix_ok  <= 1'b1;
      done_match <= 1'b1;
      streaming  <= 1'b0;
      aborted    <= 1'b0;
    end else begin
      line_count <= line_count_next;
      prefix_ok  <= prefix_ok_next;
      done_match <= done_match_next;
      streaming  <= streaming_next;
      aborted    <= aborted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (held_we) begin
      held[q[2:0]] <= c;
    end
  end

endmodule

// ----- rtl/core/sse_dlx_queue.sv -----
// Short command queue between the front and back ends of the data line extractor.
// Depends on sse_dlx_pkg.
module sse_dlx_queue
  import sse_dlx_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    pop_cmd,
  output q_stat_t stat
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign stat.full  = (count == (QPTR_W+1)'(QDEPTH));
  assign stat.empty = (count == '0);
  assign pop_cmd    = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

endmodule

// ----- rtl/core/sse_dlx_back.sv -----
// Back end of the data line extractor: expands queued commands into output words.
// Depends on sse_dlx_pkg.
module sse_dlx_back
  import sse_dlx_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cmd_t      pop_cmd,
  input  q_stat_t   q_stat,
  output logic      pop,
  output logic      msg_valid,
  input  logic      msg_stall,
  output out_word_t msg_word
);

  cmd_t       cmd;
  logic       cmd_valid;
  logic [2:0] step;

  logic       advance;
  logic       last;
  logic [3:0] total;
  out_word_t  res;

  assign total   = {1'b0, cmd.held_cnt} + {3'b000, cmd.has_tail} + {3'b000, cmd.has_end};
  assign last    = ({1'b0, step} + 4'd1) == total;
  assign advance = cmd_valid && (!msg_valid || !msg_stall);
  assign pop     = !q_stat.empty && (!cmd_valid || (advance && last));

  always_comb begin
    res = '0;
    if (step < cmd.held_cnt) begin
      res.payload_byte = cmd.held[step];
      res.byte_valid   = 1'b1;
    end else if (step == cmd.held_cnt && cmd.has_tail) begin
      res.payload_byte = cmd.tail;
      res.byte_valid   = 1'b1;
    end else begin
      res.message_end  = 1'b1;
    end
    res.run_last = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      step      <= '0;
      msg_valid <= 1'b0;
    end else begin
      if (advance) begin
        msg_valid <= 1'b1;
      end else if (!msg_stall) begin
        msg_valid <= 1'b0;
      end
      if (pop) begin
        cmd_valid <= 1'b1;
        step      <= '0;
      end else if (advance && last) begin
        cmd_valid <= 1'b0;
      end else if (advance) begin
        step <= step + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      msg_word <= res;
    end
    if (pop) begin
      cmd <= pop_cmd;
    end
  end

endmodule

// ----- verif/sse_data_line_extractor_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the server-sent-events data line extractor.
// Depends on sse_dlx_pkg and on the sse_data_line_extractor RTL.

module sse_data_line_extractor_tb;
  import sse_dlx_pkg::*;

  logic      clk;
  logic      rst = 1'b1;
  logic      rx_valid = 1'b0;
  logic      rx_stall;
  in_word_t  rx_word = '0;
  logic      msg_valid;
  logic      msg_stall = 1'b0;
  out_word_t msg_word;

  sse_data_line_extractor dut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_word   (rx_word),
    .msg_valid (msg_valid),
    .msg_stall (msg_stall),
    .msg_word  (msg_word)
  );

  // 8 ns clock period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Words the block still owes us, oldest first.
  out_word_t expected_msg_words[$];
  out_word_t want;
  int        mismatches = 0;
  int        words_sent = 0;

  // When set, the matching side runs without any idle cycles.
  bit sender_steady = 1'b0;
  bit receiver_steady = 1'b0;
  int stall_left = 0;

  // Mirror of the extractor's line state.
  int unsigned line_fill = 0;
  bit          prefix_match = 1'b1;
  logic [7:0]  held [0:5] = '{default: 8'h00};
  bit          done_seen = 1'b1;
  bit          released = 1'b0;
  bit          stopped = 1'b0;

  function automatic void start_line();
    line_fill = 0;
    prefix_match = 1'b1;
    done_seen = 1'b1;
    released = 1'b0;
  endfunction

  function automatic out_word_t msg_of(input logic [7:0] value, input logic valid,
                                       input logic last_of_msg);
    out_word_t w;
    w.payload_byte = value;
    w.byte_valid = valid;
    w.message_end = last_of_msg;
    w.run_last = 1'b0;
    return w;
  endfunction

  // Works out the words one accepted input word releases and queues them.
  function automatic void parse_sse_byte(input in_word_t w);
    out_word_t   burst[$];
    int unsigned dlen;
    int unsigned pos;
    logic [7:0]  c;
    c = w.byte_value;
    if (stopped) return;
    if (w.kind == KIND_ABORT) begin
      // The consumer gave up: nothing comes out again, not even an end marker.
      stopped = 1'b1;
      return;
    end
    if (c == CHAR_LF || c == CHAR_CR) begin
      if (line_fill == 0) return;
      if (prefix_match && line_fill > TAG_LEN) begin
        dlen = line_fill - TAG_LEN;
        if (released) begin
          burst.push_back(msg_of(8'h00, 1'b0, 1'b1));
        end else if (!(dlen == TAG_LEN && done_seen)) begin
          // Short payload: the held bytes go out only now, unless it was [DONE].
          for (int i = 0; i < dlen && i < TAG_LEN; i++)
            burst.push_back(msg_of(held[i], 1'b1, 1'b0));
          burst.push_back(msg_of(8'h00, 1'b0, 1'b1));
        end
      end
      start_line();
    end else begin
      pos = line_fill;
      // Past the line capacity bytes vanish, but the terminator still counts.
      if (pos >= LINE_CAP - 1) return;
      line_fill = pos + 1;
      if (pos < TAG_LEN) begin
        if (c != DATA_TAG[pos]) prefix_match = 1'b0;
      end else if (prefix_match) begin
        pos = pos - TAG_LEN;
        if (pos < TAG_LEN) begin
          held[pos] = c;
          if (c != DONE_TAG[pos]) done_seen = 1'b0;
        end else if (pos == TAG_LEN) begin
          // Seventh payload byte: the line cannot be [DONE], release everything held.
          for (int i = 0; i < TAG_LEN; i++)
            burst.push_back(msg_of(held[i], 1'b1, 1'b0));
          burst.push_back(msg_of(c, 1'b1, 1'b0));
          released = 1'b1;
        end else begin
          burst.push_back(msg_of(c, 1'b1, 1'b0));
        end
      end
    end
    if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
    foreach (burst[i]) expected_msg_words.push_back(burst[i]);
  endfunction

  task automatic report_field(input string name, input logic [7:0] exp_v,
                              input logic [7:0] got_v);
    $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
    mismatches++;
  endtask

  // Checks every output word the block hands over, then records the input word
  // taken at the same edge. Results are registered in the queue, command and output
  // registers after their input, so checking first never races the prediction.
  always @(posedge clk) begin
    if (!rst) begin
      if (msg_valid && !msg_stall) begin
        if (expected_msg_words.size() == 0) begin
          $display("%0t ns: unexpected word, expected none, actual %h", $time, msg_word);
          mismatches++;
        end else begin
          want = expected_msg_words.pop_front();
          if (msg_word.payload_byte !== want.payload_byte)
            report_field("payload_byte", want.payload_byte, msg_word.payload_byte);
          if (msg_word.byte_valid !== want.byte_valid)
            report_field("byte_valid", want.byte_valid, msg_word.byte_valid);
          if (msg_word.message_end !== want.message_end)
            report_field("message_end", want.message_end, msg_word.message_end);
          if (msg_word.run_last !== want.run_last)
            report_field("run_last", want.run_last, msg_word.run_last);
        end
      end
      if (rx_valid && !rx_stall) parse_sse_byte(rx_word);
    end
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // The consumer side stalls in random bursts.
  always @(negedge clk) begin
    if (receiver_steady) begin
      msg_stall = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      msg_stall = 1'b1;
      stall_left--;
    end else begin
      msg_stall = 1'b0;
      stall_left = pick_gap(1'b0);
    end
  end

  // Offers one word, holding it steady until the block takes it. Called and
  // returns at a falling edge; valid stays high into the next word unless it waits out a gap.
  task automatic send_word(input kind_t kind, input logic [7:0] value);
    int gap;
    gap = pick_gap(sender_steady);
    if (gap > 0) begin
      rx_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    rx_word.kind = kind;
    rx_word.byte_value = value;
    rx_valid = 1'b1;
    do @(posedge clk); while (rx_stall);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic send_line(input string body, input logic [7:0] term);
    for (int i = 0; i < body.len(); i++) send_word(KIND_BYTE, body[i]);
    send_word(KIND_BYTE, term);
  endtask

  task automatic send_bytes(input logic [7:0] body[$], input logic [7:0] term);
    foreach (body[i]) send_word(KIND_BYTE, body[i]);
    send_word(KIND_BYTE, term);
  endtask

  // Holds the sender off until every expected word has come out.
  task automatic wait_for_results();
    rx_valid = 1'b0;
    while (expected_msg_words.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Any byte that does not end a line.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF || b == CHAR_CR);
    return b;
  endfunction

  function automatic logic [7:0] pick_term();
    return $urandom_range(0, 1) ? CHAR_LF : CHAR_CR;
  endfunction

  task automatic test_empty_and_short_lines();
    send_word(KIND_BYTE, CHAR_LF);
    send_word(KIND_BYTE, CHAR_CR);
    send_line("data: ", CHAR_LF);
    send_line("dat", CHAR_CR);
    send_line("data: ok", CHAR_LF);
  endtask

  task automatic test_done_payload();
    send_line("data: [DONE]", CHAR_LF);
    send_line("data: [DONE]!", CHAR_CR);
    send_line("data: [DONX]", CHAR_LF);
    send_line("data: [DON", CHAR_LF);
  endtask

  task automatic test_non_data_lines();
    send_line("event: update", CHAR_LF);
    send_line("Data: abcdefg", CHAR_CR);
  endtask

  task automatic test_byte_extremes();
    logic [7:0] body[$];
    for (int i = 0; i < TAG_LEN; i++) body.push_back(DATA_TAG[i]);
    body.push_back(8'h00);
    body.push_back(8'hFF);
    body.push_back(8'h80);
    body.push_back(8'h7F);
    send_bytes(body, CHAR_LF);
  endtask

  // A data line that runs past the line capacity, then a short one to show
  // that the terminator restarted the line.
  task automatic test_long_line();
    for (int i = 0; i < TAG_LEN; i++) send_word(KIND_BYTE, DATA_TAG[i]);
    repeat (LINE_CAP + 3) send_word(KIND_BYTE, text_byte());
    send_word(KIND_BYTE, CHAR_CR);
    send_line("data: after", CHAR_LF);
  endtask

  // One random line: mostly well-formed data lines, some [DONE] look-alikes,
  // some with a broken prefix, raw noise and empty lines.
  task automatic random_line();
    logic [7:0] body[$];
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 88) begin
      for (int i = 0; i < TAG_LEN; i++) body.push_back(DATA_TAG[i]);
    end
    if (r < 62 || (r >= 78 && r < 88)) begin
      len = $urandom_range(0, 99);
      if (len < 45) len = $urandom_range(0, 6);
      else if (len < 90) len = $urandom_range(7, 20);
      else len = $urandom_range(21, 48);
      repeat (len) body.push_back(text_byte());
      if (r >= 78) body[$urandom_range(0, TAG_LEN - 1)] = text_byte();
    end else if (r < 78) begin
      for (int i = 0; i < TAG_LEN; i++) body.push_back(DONE_TAG[i]);
      case ($urandom_range(0, 3))
        0: ;
        1: body[TAG_LEN + $urandom_range(0, TAG_LEN - 1)] = text_byte();
        2: repeat ($urandom_range(1, 3)) body.push_back(text_byte());
        default: repeat ($urandom_range(1, 5)) void'(body.pop_back());
      endcase
    end else if (r < 96) begin
      // Noise may carry terminators of its own.
      repeat ($urandom_range(1, 14)) body.push_back(8'($urandom_range(0, 255)));
    end
    send_bytes(body, pick_term());
  endtask

  task automatic test_random_stream();
    int stop_at;
    int lines;
    stop_at = words_sent + 470;
    lines = 0;
    while (words_sent < stop_at) begin
      random_line();
      lines++;
      // Switch between idle-heavy and back-to-back stretches.
      if (lines % 20 == 0) begin
        sender_steady = ($urandom_range(0, 3) == 0);
        receiver_steady = ($urandom_range(0, 3) == 0);
      end
      if (lines % 37 == 0) wait_for_results();
    end
    sender_steady = 1'b0;
    receiver_steady = 1'b0;
  endtask

  // Abort in the middle of a streaming message; everything after is ignored.
  task automatic test_abort();
    for (int i = 0; i < TAG_LEN; i++) send_word(KIND_BYTE, DATA_TAG[i]);
    repeat (9) send_word(KIND_BYTE, text_byte());
    send_word(KIND_ABORT, 8'($urandom_range(0, 255)));
    send_line("data: ignored after abort", CHAR_LF);
    send_word(KIND_ABORT, 8'($urandom_range(0, 255)));
    send_line("data: x", CHAR_CR);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    start_line();
    stopped = 1'b0;

    test_empty_and_short_lines();
    test_done_payload();
    wait_for_results();
    test_non_data_lines();
    test_byte_extremes();
    test_long_line();
    test_random_stream();
    test_abort();

    wait_for_results();
    repeat (16) @(posedge clk);
    if (mismatches == 0) begin
      $display("sse_data_line_extractor_tb: PASS");
    end else begin
      $display("sse_data_line_extractor_tb: FAIL");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #100_000_000;
    $display("sse_data_line_extractor_tb: FAIL");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/sse_dlx_pkg.sv
rtl/core/sse_dlx_front.sv
rtl/core/sse_dlx_queue.sv
rtl/core/sse_dlx_back.sv
rtl/core/sse_data_line_extractor.sv
verif/sse_data_line_extractor_tb.sv
